// File: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master register access block.
package i2cm_pkg;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Byte slots of the addressing phase
  localparam logic [1:0] SLOT_ADDR = 2'd0;
  localparam logic [1:0] SLOT_REG  = 2'd1;
  localparam logic [1:0] SLOT_LAST = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Sequencer steps, one-hot
  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_S1A   = 17'h00002,
    ST_S1B   = 17'h00004,
    ST_RSPRE = 17'h00008,
    ST_S2A   = 17'h00010,
    ST_S2B   = 17'h00020,
    ST_TXLO  = 17'h00040,
    ST_TXHI  = 17'h00080,
    ST_AKLO  = 17'h00100,
    ST_AKHI  = 17'h00200,
    ST_RDLO  = 17'h00400,
    ST_RDHI  = 17'h00800,
    ST_MALO  = 17'h01000,
    ST_MAHI  = 17'h02000,
    ST_SPA   = 17'h04000,
    ST_SPB   = 17'h08000,
    ST_SPC   = 17'h10000
  } step_t;

  // One result of a tick
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       nack_seen;
    logic       busy;
    logic       done;
  } res_t;

endpackage

// File: sv/i2cm_core.sv
// Bus sequencer: state registers and the per-tick step logic.
module i2cm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [1:0]         cmd,
  input  logic [6:0]         dev_addr,
  input  logic [7:0]         reg_addr,
  input  logic [7:0]         wr_data,
  input  logic [7:0]         count,
  input  logic               sda_in,
  input  logic [15:0]        half_period,
  output i2cm_pkg::res_t     res
);

  i2cm_pkg::step_t step, step_next, st;
  logic [15:0] timer, timer_next, timer_cur;
  logic [7:0]  shift, shift_next, shift_cur;
  logic [3:0]  bit_index, bit_index_next, bit_cur, bit_inc;
  logic [7:0]  bytes_left, bytes_left_next, bytes_cur;
  logic [1:0]  slot, slot_next;
  logic [6:0]  req_dev, req_dev_next;
  logic [7:0]  req_reg, req_reg_next;
  logic [7:0]  req_data, req_data_next;
  logic        req_read, req_read_next;
  logic        nack_flag, nack_flag_next, nack_cur;
  logic        start, expire, mack;
  logic [15:0] hp;
  logic [2:0]  lv;
  logic [7:0]  rdata;
  logic        rvalid, rlast, done;
  logic [7:0]  slot1_byte, slot2_byte;
  logic [7:0]  shift_rd;

  always_comb begin
    start = (step == i2cm_pkg::ST_IDLE) &&
            (cmd inside {i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ});

    req_dev_next  = start ? dev_addr : req_dev;
    req_reg_next  = start ? reg_addr : req_reg;
    req_data_next = start ? wr_data : req_data;
    req_read_next = start ? (cmd == i2cm_pkg::CMD_READ) : req_read;

    st        = start ? i2cm_pkg::ST_S1A : step;
    timer_cur = start ? 16'd0 : timer;
    shift_cur = start ? 8'd0 : shift;
    bit_cur   = start ? 4'd0 : bit_index;
    bytes_cur = start ? ((count == 8'd0) ? 8'd1 : count) : bytes_left;
    nack_cur  = start ? 1'b0 : nack_flag;

    // Levels of the phase current during this tick: scl, sda, oe
    mack = !(bytes_cur > 8'd1);
    case (st)
      i2cm_pkg::ST_S1A, i2cm_pkg::ST_S2A: lv = 3'b111;
      i2cm_pkg::ST_S1B, i2cm_pkg::ST_S2B: lv = 3'b101;
      i2cm_pkg::ST_RSPRE:                 lv = 3'b011;
      i2cm_pkg::ST_TXLO:                  lv = {1'b0, shift_cur[7], 1'b1};
      i2cm_pkg::ST_TXHI:                  lv = {1'b1, shift_cur[7], 1'b1};
      i2cm_pkg::ST_AKLO, i2cm_pkg::ST_RDLO: lv = 3'b010;
      i2cm_pkg::ST_AKHI, i2cm_pkg::ST_RDHI: lv = 3'b110;
      i2cm_pkg::ST_MALO:                  lv = {1'b0, mack, 1'b1};
      i2cm_pkg::ST_MAHI:                  lv = {1'b1, mack, 1'b1};
      i2cm_pkg::ST_SPA:                   lv = 3'b001;
      i2cm_pkg::ST_SPB:                   lv = 3'b101;
      default:                            lv = 3'b111;
    endcase

    hp      = (half_period == 16'd0) ? 16'd1 : half_period;
    expire  = ({1'b0, timer_cur} + 17'd1) >= {1'b0, hp};
    bit_inc = bit_cur + 4'd1;
    shift_rd = {shift_cur[6:0], sda_in};
    slot1_byte = req_reg_next;
    slot2_byte = req_read_next ? {req_dev_next, 1'b1} : req_data_next;

    step_next       = st;
    timer_next      = timer_cur;
    shift_next      = shift_cur;
    bit_index_next  = bit_cur;
    bytes_left_next = bytes_cur;
    nack_flag_next  = nack_cur;
    slot_next       = slot;
    rdata  = 8'd0;
    rvalid = 1'b0;
    rlast  = 1'b0;
    done   = 1'b0;

    if (st != i2cm_pkg::ST_IDLE) begin
      if (!expire) begin
        timer_next = timer_cur + 16'd1;
      end else begin
        timer_next = 16'd0;
        case (st)
          i2cm_pkg::ST_S1A: step_next = i2cm_pkg::ST_S1B;
          i2cm_pkg::ST_S1B: begin
            shift_next     = {req_dev_next, 1'b0};
            bit_index_next = 4'd0;
            slot_next      = i2cm_pkg::SLOT_ADDR;
            step_next      = i2cm_pkg::ST_TXLO;
          end
          i2cm_pkg::ST_RSPRE: step_next = i2cm_pkg::ST_S2A;
          i2cm_pkg::ST_S2A:   step_next = i2cm_pkg::ST_S2B;
          i2cm_pkg::ST_S2B: begin
            shift_next     = slot2_byte;
            bit_index_next = 4'd0;
            slot_next      = i2cm_pkg::SLOT_LAST;
            step_next      = i2cm_pkg::ST_TXLO;
          end
          i2cm_pkg::ST_TXLO: step_next = i2cm_pkg::ST_TXHI;
          i2cm_pkg::ST_TXHI: begin
            shift_next     = {shift_cur[6:0], 1'b0};
            bit_index_next = bit_inc;
            step_next      = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                             i2cm_pkg::ST_AKLO : i2cm_pkg::ST_TXLO;
          end
          i2cm_pkg::ST_AKLO: step_next = i2cm_pkg::ST_AKHI;
          i2cm_pkg::ST_AKHI: begin
            if (sda_in) nack_flag_next = 1'b1;
            case (slot)
              i2cm_pkg::SLOT_ADDR: begin
                shift_next     = slot1_byte;
                bit_index_next = 4'd0;
                slot_next      = i2cm_pkg::SLOT_REG;
                step_next      = i2cm_pkg::ST_TXLO;
              end
              i2cm_pkg::SLOT_REG: begin
                if (req_read_next) begin
                  step_next = i2cm_pkg::ST_RSPRE;
                end else begin
                  shift_next     = slot2_byte;
                  bit_index_next = 4'd0;
                  slot_next      = i2cm_pkg::SLOT_LAST;
                  step_next      = i2cm_pkg::ST_TXLO;
                end
              end
              default: begin
                if (req_read_next) begin
                  shift_next     = 8'd0;
                  bit_index_next = 4'd0;
                  step_next      = i2cm_pkg::ST_RDLO;
                end else begin
                  step_next = i2cm_pkg::ST_SPA;
                end
              end
            endcase
          end
          i2cm_pkg::ST_RDLO: step_next = i2cm_pkg::ST_RDHI;
          i2cm_pkg::ST_RDHI: begin
            shift_next     = shift_rd;
            bit_index_next = bit_inc;
            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
              rdata     = shift_rd;
              rvalid    = 1'b1;
              rlast     = (bytes_cur <= 8'd1);
              step_next = i2cm_pkg::ST_MALO;
            end else begin
              step_next = i2cm_pkg::ST_RDLO;
            end
          end
          i2cm_pkg::ST_MALO: step_next = i2cm_pkg::ST_MAHI;
          i2cm_pkg::ST_MAHI: begin
            if (bytes_cur > 8'd1) begin
              bytes_left_next = bytes_cur - 8'd1;
              shift_next      = 8'd0;
              bit_index_next  = 4'd0;
              step_next       = i2cm_pkg::ST_RDLO;
            end else begin
              bytes_left_next = 8'd0;
              step_next       = i2cm_pkg::ST_SPA;
            end
          end
          i2cm_pkg::ST_SPA: step_next = i2cm_pkg::ST_SPB;
          i2cm_pkg::ST_SPB: step_next = i2cm_pkg::ST_SPC;
          i2cm_pkg::ST_SPC: begin
            done      = 1'b1;
            step_next = i2cm_pkg::ST_IDLE;
          end
          default: step_next = i2cm_pkg::ST_IDLE;
        endcase
      end
    end

    res.scl       = lv[2];
    res.sda_out   = lv[0] ? lv[1] : 1'b1;
    res.sda_oe    = lv[0];
    res.rd_data   = rdata;
    res.rd_valid  = rvalid;
    res.rd_last   = rlast;
    res.nack_seen = nack_flag_next;
    res.busy      = (step_next != i2cm_pkg::ST_IDLE);
    res.done      = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= i2cm_pkg::ST_IDLE;
      timer      <= 16'd0;
      shift      <= 8'd0;
      bit_index  <= 4'd0;
      bytes_left <= 8'd0;
      slot       <= i2cm_pkg::SLOT_ADDR;
      req_dev    <= 7'd0;
      req_reg    <= 8'd0;
      req_data   <= 8'd0;
      req_read   <= 1'b0;
      nack_flag  <= 1'b0;
    end else if (en) begin
      step       <= step_next;
      timer      <= timer_next;
      shift      <= shift_next;
      bit_index  <= bit_index_next;
      bytes_left <= bytes_left_next;
      slot       <= slot_next;
      req_dev    <= req_dev_next;
      req_reg    <= req_reg_next;
      req_data   <= req_data_next;
      req_read   <= req_read_next;
      nack_flag  <= nack_flag_next;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    en && res.done |=> step == i2cm_pkg::ST_IDLE)
    else $error("stop completed but sequencer not idle");

  a_byte_to_ack: assert property (@(posedge clk) disable iff (rst)
    en && res.rd_valid |=> step == i2cm_pkg::ST_MALO)
    else $error("read byte not followed by master ack phase");

  a_start_clears_nack: assert property (@(posedge clk) disable iff (rst)
    en && start && !(st == i2cm_pkg::ST_AKHI) |=> !nack_flag)
    else $error("nack flag survived a new command");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= i2cm_pkg::BITS_PER_BYTE)
    else $error("bit index out of range");

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(step))
    else $error("sequencer step not one-hot");

endmodule

// File: sv/i2cm_out_stage.sv
// Result register between the step logic and the output channel.
module i2cm_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  i2cm_pkg::res_t res_in,
  input  logic           out_stall,
  output logic           out_valid,
  output i2cm_pkg::res_t res_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

endmodule

// File: sv/i2c_master_register_access.sv
// Top level: I2C master for 7-bit register reads and writes, one bus tick per transfer.
// The result of an accepted input transfer is registered in the result register.
// Throughput: one input transfer per cycle while the output side takes results; the single
//   step of the sequencer in front of the result register sets this rate.
// Reset (rst, synchronous, active high): sequencer idle, nack clear, half_period back to 200,
//   no result pending.
module i2c_master_register_access (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input channel: one bus tick per transfer
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [6:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wr_data,
  input  logic [7:0]  count,
  input  logic        sda_in,
  // output channel: one result per tick
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl,
  output logic        sda_out,
  output logic        sda_oe,
  output logic [7:0]  rd_data,
  output logic        rd_valid,
  output logic        rd_last,
  output logic        nack_seen,
  output logic        busy_res,
  output logic        done_res
);

  logic [15:0]    half_period;
  logic           accept;
  i2cm_pkg::res_t res_comb;
  i2cm_pkg::res_t res_q;

  // The phase length register takes every write; the user must change configuration only while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  // Hold the input side only while a finished result waits and the sink stalls;
  // otherwise the result register drains and refills in the same cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Advance the bus sequencer by one tick per accepted transfer.
  i2cm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .cmd         (cmd),
    .dev_addr    (dev_addr),
    .reg_addr    (reg_addr),
    .wr_data     (wr_data),
    .count       (count),
    .sda_in      (sda_in),
    .half_period (half_period),
    .res         (res_comb)
  );

  // Register the tick result for the output channel.
  i2cm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_comb),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign scl       = res_q.scl;
  assign sda_out   = res_q.sda_out;
  assign sda_oe    = res_q.sda_oe;
  assign rd_data   = res_q.rd_data;
  assign rd_valid  = res_q.rd_valid;
  assign rd_last   = res_q.rd_last;
  assign nack_seen = res_q.nack_seen;
  assign busy_res  = res_q.busy;
  assign done_res  = res_q.done;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transfer produced no result");

endmodule
